[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define AST_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define AST_BLK(lbl, prop, msg) \
    `AST_CLK_RST(lbl, i_clk, i_rst_n, prop, msg)

`endif

[rtl/dfrw_pkg.sv]
// ----------------------------------------------------------------------------
// dfrw_pkg
// types and constants of the dashed focus rectangle walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfrw_pkg;

    localparam int FIELD_BITS   = 16;
    localparam int COLOR_BITS   = 32;
    localparam int STYLE_BITS   = 3;
    localparam int CFG_IDX_BITS = 1;
    localparam int INSET        = 2;

    // highlight style codes; codes five to seven draw like dashed
    localparam logic [STYLE_BITS-1:0] STYLE_NONE    = 3'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_DASHED  = 3'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_DOTS    = 3'd2;
    localparam logic [STYLE_BITS-1:0] STYLE_DASHDOT = 3'd3;
    localparam logic [STYLE_BITS-1:0] STYLE_SOLID   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STYLE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR = 1'd1;

    // item kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_NEXT  = 1'b1;

    // rectangle sides in walk order, also the index into the inset rectangle
    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge;

    typedef struct packed {
        logic                          has_segment;
        logic signed [FIELD_BITS-1:0]  px0;
        logic signed [FIELD_BITS-1:0]  py0;
        logic signed [FIELD_BITS-1:0]  px1;
        logic signed [FIELD_BITS-1:0]  py1;
        logic signed [FIELD_BITS-1:0]  px2;
        logic signed [FIELD_BITS-1:0]  py2;
        logic                          three_points;
        logic                          walk_done;
        logic [COLOR_BITS-1:0]         seg_color;
    } t_result;

endpackage

[rtl/dfrw_settle.sv]
// ----------------------------------------------------------------------------
// dfrw_settle
// moves the walk on to the next side that still holds a dash start, or ends the walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfrw_settle
    import dfrw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DASH_LEN   = 4,
    parameter int GAP_LEN    = 1
) (
    input  logic                                                 i_active,
    input  t_edge                                                i_edge,
    input  logic signed [COORD_BITS+$clog2(DASH_LEN+GAP_LEN):0]  i_pos,
    input  logic [$clog2(DASH_LEN+GAP_LEN)-1:0]                  i_phase,
    input  logic signed [COORD_BITS-1:0]                         i_rect [4],
    output logic                                                 o_active,
    output t_edge                                                o_edge,
    output logic signed [COORD_BITS+$clog2(DASH_LEN+GAP_LEN):0]  o_pos
);

    localparam int PH_BITS   = $clog2(DASH_LEN + GAP_LEN);
    localparam int WALK_BITS = COORD_BITS + PH_BITS + 1;

    logic                        act;
    t_edge                       e;
    logic signed [WALK_BITS-1:0] pos;
    logic signed [WALK_BITS-1:0] ph_ext;
    logic signed [COORD_BITS-1:0] st;
    logic signed [COORD_BITS-1:0] en;
    logic                        fwd;
    logic                        stop;

    function automatic void side_ends(
        input  t_edge                         side,
        input  logic signed [COORD_BITS-1:0]  rect [4],
        output logic signed [COORD_BITS-1:0]  s,
        output logic signed [COORD_BITS-1:0]  n,
        output logic                          f
    );
        case (side)
            EDGE_TOP: begin
                s = rect[0]; n = rect[2]; f = 1'b1;
            end
            EDGE_RIGHT: begin
                s = rect[1]; n = rect[3]; f = 1'b1;
            end
            EDGE_BOTTOM: begin
                s = rect[2]; n = rect[0]; f = 1'b0;
            end
            default: begin
                s = rect[3]; n = rect[1]; f = 1'b0;
            end
        endcase
    endfunction

    // at most three side changes and a final check
    always_comb begin
        act    = i_active;
        e      = i_edge;
        pos    = i_pos;
        stop   = 1'b0;
        st     = '0;
        en     = '0;
        fwd    = 1'b0;
        ph_ext = signed'(WALK_BITS'(i_phase));
        for (int k = 0; k < 4; k++) begin
            if (act && !stop) begin
                side_ends(e, i_rect, st, en, fwd);
                if (fwd ? (pos < WALK_BITS'(en)) : (pos > WALK_BITS'(en))) begin
                    stop = 1'b1;
                end else if (e == EDGE_LEFT) begin
                    act = 1'b0;
                end else begin
                    e = t_edge'(e + 2'd1);
                    side_ends(e, i_rect, st, en, fwd);
                    pos = fwd ? WALK_BITS'(st) + ph_ext : WALK_BITS'(st) - ph_ext;
                end
            end
        end
    end

    assign o_active = act;
    assign o_edge   = e;
    assign o_pos    = pos;

endmodule

[rtl/dfrw_step.sv]
// ----------------------------------------------------------------------------
// dfrw_step
// single pass over one item: inset on start, next dash otherwise
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfrw_step
    import dfrw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DASH_LEN   = 4,
    parameter int GAP_LEN    = 1
) (
    input  logic                                                 i_mode,
    input  logic signed [FIELD_BITS-1:0]                         i_item_rect [4],
    input  logic [STYLE_BITS-1:0]                                i_style,
    input  logic [COLOR_BITS-1:0]                                i_color,
    input  logic                                                 i_active,
    input  t_edge                                                i_edge,
    input  logic signed [COORD_BITS+$clog2(DASH_LEN+GAP_LEN):0]  i_pos,
    input  logic [$clog2(DASH_LEN+GAP_LEN)-1:0]                  i_phase,
    input  logic signed [COORD_BITS-1:0]                         i_rect [4],
    output logic                                                 o_active,
    output t_edge                                                o_edge,
    output logic signed [COORD_BITS+$clog2(DASH_LEN+GAP_LEN):0]  o_pos,
    output logic [$clog2(DASH_LEN+GAP_LEN)-1:0]                  o_phase,
    output logic signed [COORD_BITS-1:0]                         o_rect [4],
    output t_result                                              o_result
);

    localparam int STEP      = DASH_LEN + GAP_LEN;
    localparam int PH_BITS   = $clog2(STEP);
    localparam int WALK_BITS = COORD_BITS + PH_BITS + 1;
    localparam int WIDE_BITS = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int IN_BITS   = WIDE_BITS + 1;
    localparam int AW        = WIDE_BITS + PH_BITS + 2;

    logic signed [IN_BITS-1:0]    ins_sum [4];
    logic signed [COORD_BITS-1:0] ins_rect [4];
    logic                         draws;

    logic signed [COORD_BITS-1:0] st_c;
    logic signed [COORD_BITS-1:0] en_c;
    logic signed [COORD_BITS-1:0] fx_c;
    logic                         fwd;
    logic                         horiz;
    logic signed [AW-1:0]         p;
    logic signed [AW-1:0]         en;
    logic signed [AW-1:0]         fx;
    logic signed [AW-1:0]         nxt;
    logic signed [AW-1:0]         off_w;
    logic signed [AW-1:0]         w;
    logic signed [AW-1:0]         dash_end;
    logic signed [AW-1:0]         along1;
    logic signed [AW-1:0]         x2;
    logic signed [AW-1:0]         y2;
    logic                         over;
    logic                         bent;

    logic                         pre_active;
    t_edge                        pre_edge;
    logic signed [WALK_BITS-1:0]  pre_pos;
    logic [PH_BITS-1:0]           pre_phase;
    logic signed [COORD_BITS-1:0] set_rect [4];
    logic                         set_active;
    t_result                      res_body;

    function automatic void side_geom(
        input  t_edge                         side,
        input  logic signed [COORD_BITS-1:0]  rect [4],
        output logic signed [COORD_BITS-1:0]  s,
        output logic signed [COORD_BITS-1:0]  n,
        output logic signed [COORD_BITS-1:0]  f,
        output logic                          d
    );
        case (side)
            EDGE_TOP: begin
                s = rect[0]; n = rect[2]; f = rect[1]; d = 1'b1;
            end
            EDGE_RIGHT: begin
                s = rect[1]; n = rect[3]; f = rect[2]; d = 1'b1;
            end
            EDGE_BOTTOM: begin
                s = rect[2]; n = rect[0]; f = rect[3]; d = 1'b0;
            end
            default: begin
                s = rect[3]; n = rect[1]; f = rect[0]; d = 1'b0;
            end
        endcase
    endfunction

    // inset of the control rectangle, wrapped to the coordinate width
    always_comb begin
        ins_sum[0] = IN_BITS'(i_item_rect[0]) + IN_BITS'(INSET);
        ins_sum[1] = IN_BITS'(i_item_rect[1]) + IN_BITS'(INSET);
        ins_sum[2] = IN_BITS'(i_item_rect[2]) - IN_BITS'(INSET);
        ins_sum[3] = IN_BITS'(i_item_rect[3]) - IN_BITS'(INSET);
        for (int k = 0; k < 4; k++) begin
            ins_rect[k] = signed'(ins_sum[k][COORD_BITS-1:0]);
        end
    end

    assign draws = !(i_style == STYLE_NONE || i_style == STYLE_DOTS ||
                     i_style == STYLE_DASHDOT || i_style == STYLE_SOLID);

    // dash on the current side
    always_comb begin
        side_geom(i_edge, i_rect, st_c, en_c, fx_c, fwd);
        horiz    = (i_edge == EDGE_TOP) || (i_edge == EDGE_BOTTOM);
        p        = AW'(i_pos);
        en       = AW'(en_c);
        fx       = AW'(fx_c);
        nxt      = fwd ? p + AW'(STEP) : p - AW'(STEP);
        over     = fwd ? (nxt > en) : (nxt < en);
        off_w    = fwd ? nxt - en : en - nxt;
        bent     = over && (off_w > AW'(GAP_LEN));
        w        = off_w - AW'(GAP_LEN);
        dash_end = fwd ? p + AW'(DASH_LEN) : p - AW'(DASH_LEN);
        along1   = bent ? en : dash_end;
        case (i_edge)
            EDGE_TOP: begin
                x2 = en; y2 = fx + w;
            end
            EDGE_RIGHT: begin
                x2 = fx - w; y2 = en;
            end
            EDGE_BOTTOM: begin
                x2 = en; y2 = fx - w;
            end
            default: begin
                x2 = fx + w; y2 = en;
            end
        endcase
    end

    // state ahead of the side advance, and the result fields
    always_comb begin
        pre_active = i_active;
        pre_edge   = i_edge;
        pre_pos    = i_pos;
        pre_phase  = i_phase;
        set_rect   = i_rect;
        res_body   = '0;
        if (i_mode == MODE_START) begin
            pre_active = draws;
            pre_edge   = EDGE_TOP;
            pre_pos    = WALK_BITS'(ins_rect[0]);
            pre_phase  = '0;
            set_rect   = ins_rect;
        end else if (i_active) begin
            res_body.has_segment = 1'b1;
            res_body.seg_color   = i_color;
            res_body.px0 = horiz ? p[FIELD_BITS-1:0] : fx[FIELD_BITS-1:0];
            res_body.py0 = horiz ? fx[FIELD_BITS-1:0] : p[FIELD_BITS-1:0];
            res_body.px1 = horiz ? along1[FIELD_BITS-1:0] : fx[FIELD_BITS-1:0];
            res_body.py1 = horiz ? fx[FIELD_BITS-1:0] : along1[FIELD_BITS-1:0];
            if (bent && i_edge == EDGE_LEFT) begin
                // last side: the dash is clipped at the corner
                pre_active = 1'b0;
            end else begin
                pre_pos   = nxt[WALK_BITS-1:0];
                pre_phase = over ? off_w[PH_BITS-1:0] : '0;
                if (bent) begin
                    res_body.three_points = 1'b1;
                    res_body.px2          = x2[FIELD_BITS-1:0];
                    res_body.py2          = y2[FIELD_BITS-1:0];
                end
            end
        end
    end

    // done mark taken from the state after the side advance
    always_comb begin
        o_result           = res_body;
        o_result.walk_done = !set_active;
    end

    dfrw_settle #(
        .COORD_BITS (COORD_BITS),
        .DASH_LEN   (DASH_LEN),
        .GAP_LEN    (GAP_LEN)
    ) u_settle (
        .i_active (pre_active),
        .i_edge   (pre_edge),
        .i_pos    (pre_pos),
        .i_phase  (pre_phase),
        .i_rect   (set_rect),
        .o_active (set_active),
        .o_edge   (o_edge),
        .o_pos    (o_pos)
    );

    assign o_active = set_active;
    assign o_phase  = pre_phase;
    assign o_rect   = set_rect;

endmodule

[rtl/dashed_focus_rectangle_walker.sv]
// ----------------------------------------------------------------------------
// dashed_focus_rectangle_walker
// registers: input register, then result register
// throughput: one item per cycle while the output is not stalled; the walk state is updated in a single pass
//   through the dash step and side advance logic between the two registers
// reset: synchronous, active low; style returns to dashed, colour to 0, walk idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dashed_focus_rectangle_walker
    import dfrw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DASH_LEN   = 4,
    parameter int GAP_LEN    = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COLOR_BITS-1:0]   i_cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // rect_left, rect_top, rect_right, rect_bottom
    input  logic [4*FIELD_BITS-1:0] s_axis_tdata,
    // mode
    input  logic [0:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // px0, py0, px1, py1, px2, py2, seg_color
    output logic [6*FIELD_BITS+COLOR_BITS-1:0] m_axis_tdata,
    // has_segment, three_points
    output logic [1:0]              m_axis_tuser,
    // walk_done
    output logic                    m_axis_tlast
);

    localparam int PH_BITS   = $clog2(DASH_LEN + GAP_LEN);
    localparam int WALK_BITS = COORD_BITS + PH_BITS + 1;

    logic [STYLE_BITS-1:0]        r_style;
    logic [COLOR_BITS-1:0]        r_color;

    logic                         r_active;
    t_edge                        r_edge;
    logic signed [WALK_BITS-1:0]  r_walk_pos;
    logic [PH_BITS-1:0]           r_phase;
    logic signed [COORD_BITS-1:0] r_rect [4];

    logic                         r_in_v;
    logic                         r_in_mode;
    logic signed [FIELD_BITS-1:0] r_in_rect [4];

    logic                         r_out_v;
    t_result                      r_out_res;

    logic                         n_active;
    t_edge                        n_edge;
    logic signed [WALK_BITS-1:0]  n_walk_pos;
    logic [PH_BITS-1:0]           n_phase;
    logic signed [COORD_BITS-1:0] n_rect [4];
    t_result                      n_out_res;

    logic                         out_free;
    logic                         fire;
    logic                         in_xfer;

    assign out_free      = !r_out_v || m_axis_tready;
    assign fire          = r_in_v && out_free;
    assign s_axis_tready = !r_in_v || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style <= STYLE_DASHED;
            r_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STYLE: r_style <= i_cfg_data[STYLE_BITS-1:0];
                CFG_COLOR: r_color <= i_cfg_data;
                default:   r_style <= r_style;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_xfer) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_mode <= s_axis_tuser[0];
            for (int k = 0; k < 4; k++) begin
                r_in_rect[k] <= signed'(s_axis_tdata[k*FIELD_BITS +: FIELD_BITS]);
            end
        end
    end

    dfrw_step #(
        .COORD_BITS (COORD_BITS),
        .DASH_LEN   (DASH_LEN),
        .GAP_LEN    (GAP_LEN)
    ) u_step (
        .i_mode      (r_in_mode),
        .i_item_rect (r_in_rect),
        .i_style     (r_style),
        .i_color     (r_color),
        .i_active    (r_active),
        .i_edge      (r_edge),
        .i_pos       (r_walk_pos),
        .i_phase     (r_phase),
        .i_rect      (r_rect),
        .o_active    (n_active),
        .o_edge      (n_edge),
        .o_pos       (n_walk_pos),
        .o_phase     (n_phase),
        .o_rect      (n_rect),
        .o_result    (n_out_res)
    );

    // walk state, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_edge     <= EDGE_TOP;
            r_walk_pos <= '0;
            r_phase    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_rect[k] <= '0;
            end
        end else if (fire) begin
            r_active   <= n_active;
            r_edge     <= n_edge;
            r_walk_pos <= n_walk_pos;
            r_phase    <= n_phase;
            r_rect     <= n_rect;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res <= n_out_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_res.seg_color, r_out_res.py2, r_out_res.px2,
                            r_out_res.py1, r_out_res.px1, r_out_res.py0, r_out_res.px0};
    assign m_axis_tuser  = {r_out_res.three_points, r_out_res.has_segment};
    assign m_axis_tlast  = r_out_res.walk_done;

    // a bend only comes with a drawn segment
    `AST_BLK(a_bend_has_seg, r_out_v && r_out_res.three_points |-> r_out_res.has_segment, "bend without segment")

    // the reported end of walk agrees with the state left behind
    `AST_BLK(a_done_matches_state, $past(fire) && $past(i_rst_n) |-> r_out_res.walk_done == !r_active, "walk_done disagrees with walk state")

    // a walk only starts on a start item
    `AST_BLK(a_active_from_start, $rose(r_active) && $past(i_rst_n) |-> $past(fire) && $past(r_in_mode) == MODE_START, "walk started without start item")

    // an idle walk answers a request with nothing and a done mark
    `AST_BLK(a_idle_request, fire && !r_active && r_in_mode == MODE_NEXT |=> !r_out_res.has_segment && r_out_res.walk_done, "idle request produced a segment")

endmodule
